[hw/rtl/pcsp_pkg.sv]
package pcsp_pkg;

    localparam int COORD_W    = 32;
    localparam int OUT_W      = 34;
    localparam int GUARD_BITS = 8;
    // CORDIC x/y: 32-bit input, 8 guard bits, negation and gain growth
    localparam int XY_W       = 44;
    // angle accumulator, radians with 32 fraction bits
    localparam int Z_W        = 36;
    localparam int RAD_W      = 34;
    localparam int MUL_W      = 32;
    localparam int IDX_W      = 6;

    localparam logic signed [Z_W-1:0] PI_Q32       = 36'sd13493037705;
    localparam logic [MUL_W-1:0]      INV_GAIN_Q32 = 32'd2608131496;

    localparam logic [1:0] KIND_ANGLE     = 2'd0;
    localparam logic [1:0] KIND_RAD_PLUS  = 2'd1;
    localparam logic [1:0] KIND_RAD_MINUS = 2'd2;

    // round(atan(2^-i) * 2^32)
    function automatic logic signed [Z_W-1:0] atan_q32(input logic [IDX_W-1:0] idx);
        logic signed [Z_W-1:0] val;
        val = '0;
        case (idx)
            6'd0:    val = 36'sd3373259426;
            6'd1:    val = 36'sd1991351318;
            6'd2:    val = 36'sd1052175346;
            6'd3:    val = 36'sd534100635;
            6'd4:    val = 36'sd268086748;
            6'd5:    val = 36'sd134174063;
            6'd6:    val = 36'sd67103403;
            6'd7:    val = 36'sd33553749;
            6'd8:    val = 36'sd16777131;
            6'd9:    val = 36'sd8388597;
            6'd10:   val = 36'sd4194303;
            6'd11:   val = 36'sd2097152;
            default: begin
                if (idx <= 6'd32) begin
                    val = 36'sd1 <<< (6'd32 - idx);
                end else begin
                    val = '0;
                end
            end
        endcase
        return val;
    endfunction

endpackage

[hw/rtl/polar_corerz_stepper_position_unit.sv]
// Polar / CoreRZ stepper position unit. Each item carries one toolhead
// coordinate (x, y, z) in signed fixed point and yields one 34-bit stepper
// position in the same format. stepper_kind selects the mode: 0 gives the bed
// angle atan2(y, x), unwrapped to lie within pi of the previous angle brought
// into -pi..pi; 1 and 2 give sqrt(x^2 + y^2) plus or minus z. Both come from
// one CORDIC vectoring unit that runs one micro-rotation per clock, followed
// by a two-pass 32x32 gain correction and a final sum. An item passes through
// the micro-rotations, the low-half, high-half and sum gain-correction steps,
// the pickup of the CORDIC result and the load of the output register, with
// the unwrap and normalize steps between the last two in angle mode. The
// origin in angle mode skips the CORDIC pass and goes through unwrap and
// normalize; the unused stepper kind goes straight to the output load. A
// result blocked by a stalled receiver holds the unit for as long as the stall.
// s_ready is high only while no item is in flight, so the next item can be
// taken in the cycle after the result is registered; a finished result waits
// in the output register while the next item is accepted. Write stepper_kind
// only while the unit is idle.
module polar_corerz_stepper_position_unit #(
    parameter int FRACTION_BITS = 16,
    parameter int CORDIC_STEPS  = 24
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [1:0]                           cfg_wr_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [pcsp_pkg::COORD_W-1:0]  s_x_coord,
    input  logic signed [pcsp_pkg::COORD_W-1:0]  s_y_coord,
    input  logic signed [pcsp_pkg::COORD_W-1:0]  s_z_coord,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [pcsp_pkg::OUT_W-1:0]    m_stepper_position
);

    localparam int OUT_W  = pcsp_pkg::OUT_W;
    localparam int Z_W    = pcsp_pkg::Z_W;
    localparam int ANG_W  = FRACTION_BITS + 6;
    localparam int LAST_W = FRACTION_BITS + 4;
    localparam int SHIFT  = 32 - FRACTION_BITS;
    localparam longint PI_F_L = (longint'(pcsp_pkg::PI_Q32) + (longint'(1) << (SHIFT - 1)))
                                >>> SHIFT;
    localparam logic signed [ANG_W-1:0] PI_F     = ANG_W'(PI_F_L);
    localparam logic signed [ANG_W-1:0] TWO_PI_F = ANG_W'(2 * PI_F_L);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WAIT,
        ST_UNWRAP,
        ST_NORM,
        ST_FINISH
    } top_state_t;

    top_state_t                         state_reg;
    logic [1:0]                         kind_reg;
    logic signed [pcsp_pkg::COORD_W-1:0] z_coord_reg;
    logic signed [ANG_W-1:0]            ang_reg;
    logic signed [LAST_W-1:0]           last_angle_reg;
    logic signed [OUT_W-1:0]            res_reg;
    logic signed [OUT_W-1:0]            out_reg;
    logic                               m_valid_reg;

    logic                               accept;
    logic                               cordic_start;
    logic                               cordic_done;
    logic [pcsp_pkg::RAD_W-1:0]         cordic_radius;
    logic signed [Z_W-1:0]              cordic_angle;
    logic signed [Z_W:0]                ang_round;
    logic signed [ANG_W-1:0]            ang_frac;
    logic signed [ANG_W-1:0]            diff;
    logic signed [ANG_W-1:0]            unwrapped;
    logic signed [ANG_W-1:0]            normalized;
    logic signed [OUT_W:0]              z_ext;
    logic signed [OUT_W:0]              rad_sum;
    logic signed [OUT_W:0]              rad_diff;
    logic                               origin;

    assign accept = s_valid && s_ready;
    assign origin = (s_x_coord == '0) && (s_y_coord == '0);
    assign cordic_start = accept && ((kind_reg == pcsp_pkg::KIND_ANGLE && !origin)
                                     || kind_reg == pcsp_pkg::KIND_RAD_PLUS
                                     || kind_reg == pcsp_pkg::KIND_RAD_MINUS);

    pcsp_cordic #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_cordic (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (cordic_start),
        .x_in   (s_x_coord),
        .y_in   (s_y_coord),
        .done   (cordic_done),
        .radius (cordic_radius),
        .angle  (cordic_angle)
    );

    // round Q32 radians to the output fraction
    assign ang_round = {cordic_angle[Z_W-1], cordic_angle}
                       + ((Z_W+1)'(1) <<< (SHIFT - 1));
    assign ang_frac  = ANG_W'(ang_round >>> SHIFT);

    assign diff      = ang_reg - {{(ANG_W-LAST_W){last_angle_reg[LAST_W-1]}}, last_angle_reg};
    assign unwrapped = (diff > PI_F)  ? ang_reg - TWO_PI_F :
                       (diff < -PI_F) ? ang_reg + TWO_PI_F : ang_reg;
    assign normalized = (ang_reg < -PI_F) ? ang_reg + TWO_PI_F :
                        (ang_reg > PI_F)  ? ang_reg - TWO_PI_F : ang_reg;

    assign z_ext    = {{(OUT_W+1-pcsp_pkg::COORD_W){z_coord_reg[pcsp_pkg::COORD_W-1]}}, z_coord_reg};
    assign rad_sum  = $signed({1'b0, cordic_radius}) + z_ext;
    assign rad_diff = $signed({1'b0, cordic_radius}) - z_ext;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            kind_reg       <= pcsp_pkg::KIND_ANGLE;
            last_angle_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                kind_reg <= cfg_wr_data;
            end
            // in ST_FINISH the load below decides m_valid_reg
            if (m_valid_reg && m_ready && state_reg != ST_FINISH) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        z_coord_reg <= s_z_coord;
                        if (cordic_start) begin
                            state_reg <= ST_WAIT;
                        end else if (kind_reg == pcsp_pkg::KIND_ANGLE) begin
                            ang_reg   <= '0;
                            state_reg <= ST_UNWRAP;
                        end else begin
                            res_reg   <= '0;
                            state_reg <= ST_FINISH;
                        end
                    end
                end
                ST_WAIT: begin
                    if (cordic_done) begin
                        unique case (kind_reg)
                            pcsp_pkg::KIND_ANGLE: begin
                                ang_reg   <= ang_frac;
                                state_reg <= ST_UNWRAP;
                            end
                            pcsp_pkg::KIND_RAD_PLUS: begin
                                res_reg   <= rad_sum[OUT_W-1:0];
                                state_reg <= ST_FINISH;
                            end
                            default: begin
                                res_reg   <= rad_diff[OUT_W-1:0];
                                state_reg <= ST_FINISH;
                            end
                        endcase
                    end
                end
                ST_UNWRAP: begin
                    ang_reg   <= unwrapped;
                    res_reg   <= {{(OUT_W-ANG_W){unwrapped[ANG_W-1]}}, unwrapped};
                    state_reg <= ST_NORM;
                end
                ST_NORM: begin
                    last_angle_reg <= normalized[LAST_W-1:0];
                    state_reg      <= ST_FINISH;
                end
                ST_FINISH: begin
                    // wait for the output register to free up
                    if (!m_valid_reg || m_ready) begin
                        out_reg     <= res_reg;
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready            = (state_reg == ST_IDLE);
    assign m_valid            = m_valid_reg;
    assign m_stepper_position = out_reg;

    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        cordic_done |-> state_reg == ST_WAIT)
        else $error("CORDIC finished outside of wait state");

    a_last_angle_update: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_NORM) |=> $stable(last_angle_reg))
        else $error("last angle changed outside of normalize step");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("input ready while an item is in flight");

    a_no_result_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> m_valid_reg && $stable(out_reg))
        else $error("pending result lost");

endmodule

[hw/rtl/pcsp_cordic.sv]
module pcsp_cordic #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   start,
    input  logic signed [pcsp_pkg::COORD_W-1:0]    x_in,
    input  logic signed [pcsp_pkg::COORD_W-1:0]    y_in,
    output logic                                   done,
    output logic [pcsp_pkg::RAD_W-1:0]             radius,
    output logic signed [pcsp_pkg::Z_W-1:0]        angle
);

    localparam int CNT_W = $clog2(CORDIC_STEPS);
    localparam int XY_W  = pcsp_pkg::XY_W;
    localparam int Z_W   = pcsp_pkg::Z_W;
    localparam int MUL_W = pcsp_pkg::MUL_W;
    localparam int GB    = pcsp_pkg::GUARD_BITS;
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(CORDIC_STEPS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROTATE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SUM
    } cordic_state_t;

    cordic_state_t               state_reg;
    logic [CNT_W-1:0]            step_reg;
    logic signed [XY_W-1:0]      x_reg;
    logic signed [XY_W-1:0]      y_reg;
    logic signed [Z_W-1:0]       z_reg;
    logic [2*MUL_W-1:0]          prod_reg;
    logic [MUL_W-1:0]            t_lo_reg;
    logic [pcsp_pkg::RAD_W-1:0]  radius_reg;
    logic                        done_reg;

    logic signed [XY_W-1:0]      x_load;
    logic signed [XY_W-1:0]      y_load;
    logic signed [XY_W-1:0]      dx;
    logic signed [XY_W-1:0]      dy;
    logic signed [Z_W-1:0]       atan_val;
    logic [XY_W-1:0]             mag;
    logic [MUL_W-1:0]            mul_a;
    logic [2*MUL_W-1:0]          t_sum;

    assign x_load   = {{(XY_W-pcsp_pkg::COORD_W-GB){x_in[pcsp_pkg::COORD_W-1]}}, x_in, GB'(0)};
    assign y_load   = {{(XY_W-pcsp_pkg::COORD_W-GB){y_in[pcsp_pkg::COORD_W-1]}}, y_in, GB'(0)};
    assign dx       = y_reg >>> step_reg;
    assign dy       = x_reg >>> step_reg;
    assign atan_val = pcsp_pkg::atan_q32(pcsp_pkg::IDX_W'(step_reg));

    // magnitude clamped at zero, split for the 32x32 multiplier
    assign mag   = (x_reg > 0) ? x_reg : '0;
    assign mul_a = (state_reg == ST_MUL_LO) ? mag[MUL_W-1:0]
                                            : MUL_W'(mag[XY_W-1:MUL_W]);
    assign t_sum = prod_reg + {{MUL_W{1'b0}}, t_lo_reg} + 64'd128;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (start) begin
                        step_reg <= '0;
                        if (x_load < 0) begin
                            x_reg <= -x_load;
                            y_reg <= -y_load;
                            z_reg <= (y_load >= 0) ? pcsp_pkg::PI_Q32 : -pcsp_pkg::PI_Q32;
                        end else begin
                            x_reg <= x_load;
                            y_reg <= y_load;
                            z_reg <= '0;
                        end
                        state_reg <= ST_ROTATE;
                    end
                end
                ST_ROTATE: begin
                    if (y_reg >= 0) begin
                        x_reg <= x_reg + dx;
                        y_reg <= y_reg - dy;
                        z_reg <= z_reg + atan_val;
                    end else begin
                        x_reg <= x_reg - dx;
                        y_reg <= y_reg + dy;
                        z_reg <= z_reg - atan_val;
                    end
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == LAST_STEP) begin
                        state_reg <= ST_MUL_LO;
                    end
                end
                ST_MUL_LO: begin
                    prod_reg  <= mul_a * pcsp_pkg::INV_GAIN_Q32;
                    state_reg <= ST_MUL_HI;
                end
                ST_MUL_HI: begin
                    t_lo_reg  <= prod_reg[2*MUL_W-1:MUL_W];
                    prod_reg  <= mul_a * pcsp_pkg::INV_GAIN_Q32;
                    state_reg <= ST_SUM;
                end
                ST_SUM: begin
                    radius_reg <= t_sum[GB +: pcsp_pkg::RAD_W];
                    done_reg   <= 1'b1;
                    state_reg  <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign done   = done_reg;
    assign radius = radius_reg;
    assign angle  = z_reg;

endmodule

[bench/tb_polar_corerz_stepper_position_unit.sv]
`timescale 1ns / 100ps

module tb_polar_corerz_stepper_position_unit;

    localparam int COORD_W     = pcsp_pkg::COORD_W;
    localparam int OUT_W       = pcsp_pkg::OUT_W;
    localparam int GUARD_BITS  = pcsp_pkg::GUARD_BITS;
    localparam logic [1:0] KIND_ANGLE     = pcsp_pkg::KIND_ANGLE;
    localparam logic [1:0] KIND_RAD_PLUS  = pcsp_pkg::KIND_RAD_PLUS;
    localparam logic [1:0] KIND_RAD_MINUS = pcsp_pkg::KIND_RAD_MINUS;

    localparam int FRAC_BITS   = 16;
    localparam int STEPS       = 24;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 40;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam longint PI_Q = longint'(pcsp_pkg::PI_Q32);
    localparam longint PI_F = (PI_Q + (64'sd1 <<< (31 - FRAC_BITS))) >>> (32 - FRAC_BITS);
    localparam logic [63:0] INV_GAIN = 64'd2608131496;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } coord_t;

    logic                        aclk = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        cfg_wr_en = 1'b0;
    logic [1:0]                  cfg_wr_data = 2'd0;
    logic                        s_valid = 1'b0;
    logic                        s_ready;
    logic signed [COORD_W-1:0]   s_x_coord = '0;
    logic signed [COORD_W-1:0]   s_y_coord = '0;
    logic signed [COORD_W-1:0]   s_z_coord = '0;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic signed [OUT_W-1:0]     m_stepper_position;

    coord_t                      coord_q[$];
    logic signed [OUT_W-1:0]     position_q[$];

    logic [1:0]                  kind_model = KIND_ANGLE;
    longint                      bed_angle = 0;
    int                          mismatch_cnt = 0;
    int                          send_idle_pct = 0;
    int                          recv_stall_pct = 0;
    logic                        in_taken = 1'b0;
    logic                        hold_go = 1'b0;
    logic                        rx_hold = 1'b0;
    real                         walk_ang = 0.0;

    polar_corerz_stepper_position_unit uut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_x_coord          (s_x_coord),
        .s_y_coord          (s_y_coord),
        .s_z_coord          (s_z_coord),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_stepper_position (m_stepper_position)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic longint atan_step(input int idx);
        longint tbl[12];
        tbl = '{64'd3373259426, 64'd1991351318, 64'd1052175346, 64'd534100635,
                64'd268086748, 64'd134174063, 64'd67103403, 64'd33553749,
                64'd16777131, 64'd8388597, 64'd4194303, 64'd2097152};
        if (idx < 12) begin
            return tbl[idx];
        end else if (idx <= 32) begin
            return 64'sd1 <<< (32 - idx);
        end
        return 0;
    endfunction

    // Vectoring pass: radius in output scale, angle in Q32 radians
    function automatic void cordic_vector(input longint xi, input longint yi,
                                          output longint radius, output longint ang_q32);
        longint      xv;
        longint      yv;
        longint      zv;
        longint      dx;
        longint      dy;
        logic [63:0] mag;
        logic [63:0] gained;
        int          i;
        xv = xi <<< GUARD_BITS;
        yv = yi <<< GUARD_BITS;
        zv = 0;
        if (xv < 0) begin
            zv = (yv >= 0) ? PI_Q : -PI_Q;
            xv = -xv;
            yv = -yv;
        end
        for (i = 0; i < STEPS; i++) begin
            dx = yv >>> i;
            dy = xv >>> i;
            if (yv >= 0) begin
                xv = xv + dx;
                yv = yv - dy;
                zv = zv + atan_step(i);
            end else begin
                xv = xv - dx;
                yv = yv + dy;
                zv = zv - atan_step(i);
            end
        end
        mag = (xv > 0) ? 64'(xv) : 64'd0;
        gained = (mag >> 32) * INV_GAIN + (((mag & 64'hFFFF_FFFF) * INV_GAIN) >> 32);
        radius = longint'((gained + (64'd1 << (GUARD_BITS - 1))) >> GUARD_BITS);
        ang_q32 = zv;
    endfunction

    function automatic logic signed [OUT_W-1:0] predict_position(
            input longint xc, input longint yc, input longint zc);
        longint radius;
        longint ang_q32;
        longint ang;
        longint pos;
        radius = 0;
        ang_q32 = 0;
        pos = 0;
        if (kind_model == KIND_ANGLE) begin
            ang = 0;
            if (xc != 0 || yc != 0) begin
                cordic_vector(xc, yc, radius, ang_q32);
                ang = (ang_q32 + (64'sd1 <<< (31 - FRAC_BITS))) >>> (32 - FRAC_BITS);
            end
            // one unwrap step toward the last angle, as normalized into -pi..pi
            if (ang - bed_angle > PI_F) begin
                ang = ang - 2 * PI_F;
            end else if (ang - bed_angle < -PI_F) begin
                ang = ang + 2 * PI_F;
            end
            pos = ang;
            if (ang < -PI_F) begin
                ang = ang + 2 * PI_F;
            end else if (ang > PI_F) begin
                ang = ang - 2 * PI_F;
            end
            bed_angle = ang;
        end else if (kind_model == KIND_RAD_PLUS || kind_model == KIND_RAD_MINUS) begin
            cordic_vector(xc, yc, radius, ang_q32);
            pos = (kind_model == KIND_RAD_PLUS) ? radius + zc : radius - zc;
        end
        return pos[OUT_W-1:0];
    endfunction

    // sender
    always @(negedge aclk) begin
        coord_t it;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_taken) begin
            if (coord_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                it = coord_q.pop_front();
                s_valid <= 1'b1;
                s_x_coord <= it.x;
                s_y_coord <= it.y;
                s_z_coord <= it.z;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge aclk) begin
        m_ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        wait (hold_go);
        @(posedge aclk);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        rx_hold = 1'b0;
    end

    // monitor and checker
    always @(posedge aclk) begin
        logic signed [OUT_W-1:0] exp_pos;
        if (!aresetn) begin
            in_taken = 1'b0;
        end else begin
            in_taken = s_valid && s_ready;
            if (in_taken) begin
                position_q.push_back(predict_position(s_x_coord, s_y_coord, s_z_coord));
            end
            if (m_valid && m_ready) begin
                if (position_q.size() == 0) begin
                    mismatch_cnt++;
                    $display("%0t: unexpected item, expected none actual %0d",
                             $time, m_stepper_position);
                end else begin
                    exp_pos = position_q.pop_front();
                    if (m_stepper_position !== exp_pos) begin
                        mismatch_cnt++;
                        $display("%0t: stepper_position mismatch, expected %0d actual %0d",
                                 $time, exp_pos, m_stepper_position);
                    end
                end
            end
        end
    end

    task automatic add_item(input logic signed [COORD_W-1:0] xc,
                            input logic signed [COORD_W-1:0] yc,
                            input logic signed [COORD_W-1:0] zc);
        coord_t it;
        it.x = xc;
        it.y = yc;
        it.z = zc;
        coord_q.push_back(it);
    endtask

    task automatic wait_drained();
        while (coord_q.size() != 0 || s_valid || position_q.size() != 0) begin
            @(posedge aclk);
        end
        @(negedge aclk);
    endtask

    task automatic set_phase(input logic [1:0] kind, input int sidle, input int rstall);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= kind;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        kind_model = kind;
        send_idle_pct = sidle;
        recv_stall_pct = rstall;
    endtask

    // mix of full-range noise, small values, origin, axes and a point
    // walking around the origin so the angle keeps wrapping
    task automatic add_random(input int n);
        int     k;
        int     sel;
        int     sm;
        real    rad_r;
        logic signed [COORD_W-1:0] xc;
        logic signed [COORD_W-1:0] yc;
        logic signed [COORD_W-1:0] zc;
        for (k = 0; k < n; k++) begin
            sel = $urandom_range(99);
            zc = $urandom();
            if (sel < 45) begin
                walk_ang = walk_ang + (real'(int'($urandom_range(2000)) - 1000) / 1000.0) * 1.3;
                if ($urandom_range(9) == 0) begin
                    walk_ang = walk_ang + 3.14159;
                end
                rad_r = 2.0 ** $urandom_range(4, 30);
                xc = $rtoi(rad_r * $cos(walk_ang));
                yc = $rtoi(rad_r * $sin(walk_ang));
                if ($urandom_range(1) == 1) begin
                    zc = int'($urandom_range(1 << 22)) - (1 << 21);
                end
            end else if (sel < 75) begin
                xc = $urandom();
                yc = $urandom();
            end else if (sel < 88) begin
                sm = int'($urandom_range(2000)) - 1000;
                xc = sm;
                sm = int'($urandom_range(2000)) - 1000;
                yc = sm;
                sm = int'($urandom_range(2000)) - 1000;
                zc = sm;
            end else if (sel < 93) begin
                xc = '0;
                yc = '0;
            end else if (sel < 97) begin
                xc = $urandom();
                yc = '0;
            end else begin
                xc = '0;
                yc = $urandom();
            end
            add_item(xc, yc, zc);
        end
    endtask

    localparam logic signed [COORD_W-1:0] CMAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] CMIN = 32'sh8000_0000;
    localparam logic signed [COORD_W-1:0] ONE  = 32'sd65536;

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: radius modes at the extremes
        set_phase(KIND_RAD_PLUS, 0, 0);
        add_item(CMAX, CMAX, CMAX);
        add_item(CMIN, CMIN, CMIN);
        add_item(CMIN, CMAX, 0);
        add_item(0, 0, CMIN);
        add_item(0, 0, 0);
        add_item(-1, -1, 1);
        add_item(ONE, 0, 0);
        add_item(0, -ONE, ONE);
        set_phase(KIND_RAD_MINUS, 0, 0);
        add_item(CMAX, 0, CMIN);
        add_item(CMIN, CMIN, CMAX);
        add_item(3 * ONE, 4 * ONE, ONE);

        // directed: angle mode, origin, axes and unwrap both ways near pi
        set_phase(KIND_ANGLE, 0, 0);
        add_item(0, 0, 0);
        add_item(ONE, 0, 0);
        add_item(0, ONE, 0);
        add_item(-ONE, 0, 0);
        add_item(0, -ONE, 0);
        add_item(-ONE, 100, 0);
        add_item(-ONE, -100, 0);
        add_item(-ONE, 100, 0);
        add_item(CMIN, CMIN, CMAX);
        add_item(CMAX, CMAX, CMIN);
        add_item(CMIN, 0, 0);
        add_item(0, 0, 0);

        // unused kind answers zero
        set_phase(KIND_UNUSED, 0, 0);
        add_item(CMAX, CMIN, CMAX);
        add_item(0, 0, 0);

        // random phases
        set_phase(KIND_RAD_PLUS, 0, 0);
        add_random(60);
        set_phase(KIND_ANGLE, 75, 0);
        add_random(60);
        set_phase(KIND_RAD_MINUS, 0, 75);
        add_random(60);
        set_phase(KIND_ANGLE, 33, 33);
        add_random(60);
        set_phase(KIND_UNUSED, 33, 33);
        add_random(20);

        // receiver holds off while items keep coming
        set_phase(KIND_RAD_PLUS, 0, 0);
        hold_go = 1'b1;
        add_random(30);

        set_phase(KIND_ANGLE, 0, 0);
        add_random(30);
        // sender waits for every result before going on
        wait_drained();
        add_random(30);
        set_phase(KIND_RAD_MINUS, 33, 33);
        add_random(50);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (position_q.size() != 0) begin
            mismatch_cnt++;
            $display("%0t: items missing, expected %0d more actual 0",
                     $time, position_q.size());
        end
        if (mismatch_cnt == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
